>>> rtl/fpnb_pkg.sv
// ----------------------------------------------------------------------------
// fpnb_pkg
// Shared types and constants of the farthest point net builder.
// ----------------------------------------------------------------------------
package fpnb_pkg;

  localparam int unsigned MAX_POINTS = 4096;
  localparam int unsigned MAX_SITES  = 256;
  localparam int unsigned DIMS       = 16;
  localparam int unsigned COORD_BITS = 16;

  localparam int unsigned PT_W      = $clog2(MAX_POINTS);
  localparam int unsigned NPTS_W    = PT_W + 1;
  localparam int unsigned SITE_W    = $clog2(MAX_SITES);
  localparam int unsigned NSITE_W   = SITE_W + 1;
  localparam int unsigned DIM_W     = $clog2(DIMS);
  localparam int unsigned COORD_AW  = PT_W + DIM_W;
  localparam int unsigned DIST_W    = 40;
  localparam int unsigned SQ_W      = 2 * COORD_BITS;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = NPTS_W;

  localparam logic [DIST_W-1:0]    DIST_MAX  = '1;
  localparam logic [DIM_W-1:0]     DIM_LAST  = DIM_W'(DIMS - 1);
  localparam logic [NPTS_W-1:0]    PTS_RESET = NPTS_W'(MAX_POINTS);
  localparam logic [NSITE_W-1:0]   SITES_RESET = NSITE_W'(16);

  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IN_USE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SITES_WANTED  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    KIND_LOAD      = 2'd0,
    KIND_RUN       = 2'd1,
    KIND_READ_SITE = 2'd2,
    KIND_READ_CELL = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_RANGE  = 2'd1,
    STATUS_NO_RUN = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SITE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  // one coordinate read travelling down the distance pipeline
  typedef struct packed {
    logic             valid;
    logic             load_site;
    logic             first;
    logic             last;
    logic [DIM_W-1:0] dim;
    logic [PT_W-1:0]  point;
  } tag_t;

  // request to fetch a point's current nearest distance
  typedef struct packed {
    logic            valid;
    logic [PT_W-1:0] point;
  } nreq_t;

  // finished squared distance of one point to the current site
  typedef struct packed {
    logic              valid;
    logic [PT_W-1:0]   point;
    logic [DIST_W-1:0] dsq;
  } dres_t;

endpackage

>>> rtl/fpnb_cmd_if.sv
// ----------------------------------------------------------------------------
// fpnb_cmd_if
// Command channel: loads, run and read requests.
// ----------------------------------------------------------------------------
interface fpnb_cmd_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             kind;
  logic [fpnb_pkg::PT_W-1:0]              point_index;
  logic [fpnb_pkg::DIM_W-1:0]             coord_index;
  logic signed [fpnb_pkg::COORD_BITS-1:0] coord_value;
  logic [fpnb_pkg::SITE_W-1:0]            site_index;

  modport source (
    output valid, kind, point_index, coord_index, coord_value, site_index,
    input  ready
  );
  modport sink (
    input  valid, kind, point_index, coord_index, coord_value, site_index,
    output ready
  );
endinterface

>>> rtl/fpnb_rsp_if.sv
// ----------------------------------------------------------------------------
// fpnb_rsp_if
// Response channel: one response per command.
// ----------------------------------------------------------------------------
interface fpnb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [fpnb_pkg::PT_W-1:0]     point_id;
  logic [fpnb_pkg::DIST_W-1:0]   sq_distance;

  modport source (
    output valid, status, point_id, sq_distance,
    input  ready
  );
  modport sink (
    input  valid, status, point_id, sq_distance,
    output ready
  );
endinterface

>>> rtl/fpnb_cfg_if.sv
// ----------------------------------------------------------------------------
// fpnb_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface fpnb_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [fpnb_pkg::CFG_IDX_W-1:0]     index;
  logic [fpnb_pkg::CFG_DAT_W-1:0]     data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

>>> rtl/farthest_point_net_builder_unit.sv
// ----------------------------------------------------------------------------
// farthest_point_net_builder_unit
// Greedy farthest point net over up to 4096 points of 16 dimensions.
// ----------------------------------------------------------------------------
// Channels: cfg_i writes points_in_use (index 0) and sites_wanted (index 1),
// always ready; cmd_i carries one command per transfer; rsp_o returns exactly
// one response per command, in order. Commands are taken one at a time.
// Response timing: a coordinate load or an error response appears in the cycle
// after its transfer; a site or cell read passes through the ST_READ state and
// then the output register. A run makes m site passes for n points and m sites: each site pass loads the
// site's 16 coordinates, then streams every coordinate of every point through
// the single read port of the coordinate RAM, one per cycle, and drains the
// distance pipeline before the next site is known.
// Throughput: one command per cycle for loads when rsp_o is ready.
// Reset clears the registers to 4096 points and 16 sites and forgets any run;
// the RAM contents are not cleared. When the receiver stalls, the response is
// held in the output register and cmd_i.ready stays low until it is taken.
// ----------------------------------------------------------------------------
module farthest_point_net_builder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpnb_cfg_if.sink   cfg_i,
  fpnb_cmd_if.sink   cmd_i,
  fpnb_rsp_if.source rsp_o
);

  fpnb_pkg::state_e state_q, state_d;

  logic [fpnb_pkg::NPTS_W-1:0]  pin_q;
  logic [fpnb_pkg::NSITE_W-1:0] sw_q;
  logic [fpnb_pkg::NPTS_W-1:0]  n_sat;
  logic [fpnb_pkg::NSITE_W-1:0] m_sat;
  logic [fpnb_pkg::NPTS_W-1:0]  run_pts_q;
  logic [fpnb_pkg::NSITE_W-1:0] run_sites_q;
  logic                         run_done_q;

  logic [fpnb_pkg::DIM_W-1:0]   dim_q, dim_d;
  logic [fpnb_pkg::PT_W-1:0]    pt_q, pt_d;
  logic [fpnb_pkg::PT_W-1:0]    site_q, site_d;
  logic [fpnb_pkg::SITE_W-1:0]  site_cnt_q, site_cnt_d;
  logic                         first_pass_q, first_pass_d;
  logic [fpnb_pkg::PT_W-1:0]    far_q, far_d;
  logic [fpnb_pkg::DIST_W-1:0]  sep_q, sep_d;
  logic                         far_valid_q, far_valid_d;
  fpnb_pkg::kind_e              rd_kind_q;

  logic                         out_valid_q, out_valid_d;
  fpnb_pkg::status_e            out_status_q, out_status_d;
  logic [fpnb_pkg::PT_W-1:0]    out_pid_q, out_pid_d;
  logic [fpnb_pkg::DIST_W-1:0]  out_dist_q, out_dist_d;

  logic cmd_acc, rsp_take, run_start, pass_start, run_finish;
  logic rd_site_ok, rd_cell_ok;
  logic [fpnb_pkg::NPTS_W-1:0]  pts_minus1;
  logic [fpnb_pkg::PT_W-1:0]    pt_last;
  logic [fpnb_pkg::NSITE_W-1:0] site_next;
  fpnb_pkg::kind_e              kind;

  // coordinate RAM ports
  logic                            coord_re;
  logic [fpnb_pkg::COORD_AW-1:0]   coord_raddr;
  logic [fpnb_pkg::COORD_BITS-1:0] coord_rdata;
  fpnb_pkg::tag_t                  tag;

  // nearest distance / nearest site / site list RAM ports
  logic                          nd_re, nd_we, ns_re, sl_re, sl_we;
  logic [fpnb_pkg::PT_W-1:0]     nd_raddr;
  logic [fpnb_pkg::DIST_W-1:0]   nd_rdata;
  logic [fpnb_pkg::PT_W-1:0]     ns_rdata;
  logic [fpnb_pkg::SITE_W-1:0]   sl_waddr;
  logic [fpnb_pkg::PT_W-1:0]     sl_wdata;
  logic [fpnb_pkg::PT_W-1:0]     sl_rdata;

  fpnb_pkg::nreq_t nreq;
  fpnb_pkg::dres_t dres;
  logic            dist_busy;
  logic            take_new;
  logic [fpnb_pkg::DIST_W-1:0] nd_val;

  assign kind     = fpnb_pkg::kind_e'(cmd_i.kind);
  assign cmd_i.ready = (state_q == fpnb_pkg::ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign cmd_acc  = cmd_i.valid & cmd_i.ready;
  assign rsp_take = out_valid_q & rsp_o.ready;
  assign cfg_i.ready = 1'b1;

  // register values clamp into range when a run starts
  always_comb begin
    if (pin_q == '0) begin
      n_sat = fpnb_pkg::NPTS_W'(1);
    end else if (pin_q > fpnb_pkg::PTS_RESET) begin
      n_sat = fpnb_pkg::PTS_RESET;
    end else begin
      n_sat = pin_q;
    end
    if (sw_q == '0) begin
      m_sat = fpnb_pkg::NSITE_W'(1);
    end else if (sw_q > fpnb_pkg::NSITE_W'(fpnb_pkg::MAX_SITES)) begin
      m_sat = fpnb_pkg::NSITE_W'(fpnb_pkg::MAX_SITES);
    end else begin
      m_sat = sw_q;
    end
  end

  assign pts_minus1 = run_pts_q - fpnb_pkg::NPTS_W'(1);
  assign pt_last    = pts_minus1[fpnb_pkg::PT_W-1:0];
  assign site_next  = {1'b0, site_cnt_q} + fpnb_pkg::NSITE_W'(1);
  assign rd_site_ok = run_done_q && ({1'b0, cmd_i.site_index} < run_sites_q);
  assign rd_cell_ok = run_done_q && ({1'b0, cmd_i.point_index} < run_pts_q);

  // sequencer
  always_comb begin
    state_d      = state_q;
    dim_d        = dim_q;
    pt_d         = pt_q;
    site_d       = site_q;
    site_cnt_d   = site_cnt_q;
    first_pass_d = first_pass_q;
    run_start    = 1'b0;
    pass_start   = 1'b0;
    run_finish   = 1'b0;
    coord_re     = 1'b0;
    coord_raddr  = {site_q, dim_q};
    tag          = '0;
    sl_we        = 1'b0;
    sl_waddr     = '0;
    sl_wdata     = '0;
    unique case (state_q)
      fpnb_pkg::ST_IDLE: begin
        if (cmd_acc) begin
          unique case (kind)
            fpnb_pkg::KIND_LOAD: begin
            end
            fpnb_pkg::KIND_RUN: begin
              run_start    = 1'b1;
              site_d       = '0;
              site_cnt_d   = '0;
              first_pass_d = 1'b1;
              dim_d        = '0;
              sl_we        = 1'b1;
              state_d      = fpnb_pkg::ST_SITE;
            end
            fpnb_pkg::KIND_READ_SITE: begin
              if (rd_site_ok) begin
                state_d = fpnb_pkg::ST_READ;
              end
            end
            fpnb_pkg::KIND_READ_CELL: begin
              if (rd_cell_ok) begin
                state_d = fpnb_pkg::ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      fpnb_pkg::ST_READ: begin
        state_d = fpnb_pkg::ST_IDLE;
      end
      fpnb_pkg::ST_SITE: begin
        coord_re      = 1'b1;
        coord_raddr   = {site_q, dim_q};
        tag.valid     = 1'b1;
        tag.load_site = 1'b1;
        tag.dim       = dim_q;
        dim_d         = dim_q + fpnb_pkg::DIM_W'(1);
        if (dim_q == fpnb_pkg::DIM_LAST) begin
          dim_d   = '0;
          pt_d    = '0;
          state_d = fpnb_pkg::ST_SCAN;
        end
      end
      fpnb_pkg::ST_SCAN: begin
        coord_re    = 1'b1;
        coord_raddr = {pt_q, dim_q};
        tag.valid   = 1'b1;
        tag.first   = (dim_q == '0);
        tag.last    = (dim_q == fpnb_pkg::DIM_LAST);
        tag.dim     = dim_q;
        tag.point   = pt_q;
        dim_d       = dim_q + fpnb_pkg::DIM_W'(1);
        if (dim_q == fpnb_pkg::DIM_LAST) begin
          dim_d = '0;
          pt_d  = pt_q + fpnb_pkg::PT_W'(1);
          if (pt_q == pt_last) begin
            state_d = fpnb_pkg::ST_DRAIN;
          end
        end
      end
      fpnb_pkg::ST_DRAIN: begin
        // far_q is final once the pipeline is empty
        if (!dist_busy) begin
          if (site_next < run_sites_q) begin
            site_cnt_d   = site_next[fpnb_pkg::SITE_W-1:0];
            site_d       = far_q;
            first_pass_d = 1'b0;
            pass_start   = 1'b1;
            dim_d        = '0;
            sl_we        = 1'b1;
            sl_waddr     = site_next[fpnb_pkg::SITE_W-1:0];
            sl_wdata     = far_q;
            state_d      = fpnb_pkg::ST_SITE;
          end else begin
            run_finish = 1'b1;
            state_d    = fpnb_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = fpnb_pkg::ST_IDLE;
      end
    endcase
  end

  // nearest site update and farthest point tracking
  always_comb begin
    take_new    = first_pass_q || (dres.dsq < nd_rdata);
    nd_val      = take_new ? dres.dsq : nd_rdata;
    nd_we       = dres.valid & take_new;
    far_d       = far_q;
    sep_d       = sep_q;
    far_valid_d = far_valid_q;
    if (dres.valid && (!far_valid_q || nd_val > sep_q)) begin
      far_d       = dres.point;
      sep_d       = nd_val;
      far_valid_d = 1'b1;
    end
    if (run_start || pass_start) begin
      far_valid_d = 1'b0;
    end
  end

  assign nd_re    = nreq.valid | (cmd_acc && kind == fpnb_pkg::KIND_READ_CELL && rd_cell_ok);
  assign nd_raddr = nreq.valid ? nreq.point : cmd_i.point_index;
  assign ns_re    = cmd_acc && kind == fpnb_pkg::KIND_READ_CELL && rd_cell_ok;
  assign sl_re    = cmd_acc && kind == fpnb_pkg::KIND_READ_SITE && rd_site_ok;

  // response register
  always_comb begin
    out_valid_d  = out_valid_q & ~rsp_take;
    out_status_d = out_status_q;
    out_pid_d    = out_pid_q;
    out_dist_d   = out_dist_q;
    if (cmd_acc) begin
      case (kind) inside
        fpnb_pkg::KIND_LOAD: begin
          out_valid_d  = 1'b1;
          out_status_d = fpnb_pkg::STATUS_OK;
          out_pid_d    = '0;
          out_dist_d   = '0;
        end
        fpnb_pkg::KIND_READ_SITE, fpnb_pkg::KIND_READ_CELL: begin
          if (!run_done_q) begin
            out_valid_d  = 1'b1;
            out_status_d = fpnb_pkg::STATUS_NO_RUN;
            out_pid_d    = '0;
            out_dist_d   = '0;
          end else if ((kind == fpnb_pkg::KIND_READ_SITE && !rd_site_ok) ||
                       (kind == fpnb_pkg::KIND_READ_CELL && !rd_cell_ok)) begin
            out_valid_d  = 1'b1;
            out_status_d = fpnb_pkg::STATUS_RANGE;
            out_pid_d    = '0;
            out_dist_d   = '0;
          end
        end
        default: begin
        end
      endcase
    end
    if (state_q == fpnb_pkg::ST_READ) begin
      out_valid_d  = 1'b1;
      out_status_d = fpnb_pkg::STATUS_OK;
      if (rd_kind_q == fpnb_pkg::KIND_READ_SITE) begin
        out_pid_d  = sl_rdata;
        out_dist_d = '0;
      end else begin
        out_pid_d  = ns_rdata;
        out_dist_d = nd_rdata;
      end
    end
    if (run_finish) begin
      out_valid_d  = 1'b1;
      out_status_d = fpnb_pkg::STATUS_OK;
      out_pid_d    = far_q;
      out_dist_d   = sep_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= fpnb_pkg::ST_IDLE;
      pin_q        <= fpnb_pkg::PTS_RESET;
      sw_q         <= fpnb_pkg::SITES_RESET;
      run_pts_q    <= '0;
      run_sites_q  <= '0;
      run_done_q   <= 1'b0;
      dim_q        <= '0;
      pt_q         <= '0;
      site_q       <= '0;
      site_cnt_q   <= '0;
      first_pass_q <= 1'b0;
      far_q        <= '0;
      sep_q        <= '0;
      far_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      dim_q        <= dim_d;
      pt_q         <= pt_d;
      site_q       <= site_d;
      site_cnt_q   <= site_cnt_d;
      first_pass_q <= first_pass_d;
      far_q        <= far_d;
      sep_q        <= sep_d;
      far_valid_q  <= far_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          fpnb_pkg::CFG_POINTS_IN_USE: pin_q <= cfg_i.data;
          fpnb_pkg::CFG_SITES_WANTED:  sw_q  <= cfg_i.data[fpnb_pkg::NSITE_W-1:0];
          default: begin
          end
        endcase
      end
      if (run_start) begin
        run_pts_q   <= n_sat;
        run_sites_q <= m_sat;
      end
      if (run_finish) begin
        run_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_pid_q    <= out_pid_d;
    out_dist_q   <= out_dist_d;
    if (cmd_acc) begin
      rd_kind_q <= kind;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.point_id    = out_pid_q;
  assign rsp_o.sq_distance = out_dist_q;

  fpnb_ram #(
    .WIDTH (fpnb_pkg::COORD_BITS),
    .DEPTH (fpnb_pkg::MAX_POINTS * fpnb_pkg::DIMS)
  ) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_acc && kind == fpnb_pkg::KIND_LOAD),
    .waddr_i ({cmd_i.point_index, cmd_i.coord_index}),
    .wdata_i (cmd_i.coord_value),
    .re_i    (coord_re),
    .raddr_i (coord_raddr),
    .rdata_o (coord_rdata)
  );

  fpnb_ram #(
    .WIDTH (fpnb_pkg::DIST_W),
    .DEPTH (fpnb_pkg::MAX_POINTS)
  ) u_near_dist_ram (
    .clk_i   (clk_i),
    .we_i    (nd_we),
    .waddr_i (dres.point),
    .wdata_i (dres.dsq),
    .re_i    (nd_re),
    .raddr_i (nd_raddr),
    .rdata_o (nd_rdata)
  );

  fpnb_ram #(
    .WIDTH (fpnb_pkg::PT_W),
    .DEPTH (fpnb_pkg::MAX_POINTS)
  ) u_near_site_ram (
    .clk_i   (clk_i),
    .we_i    (nd_we),
    .waddr_i (dres.point),
    .wdata_i (site_q),
    .re_i    (ns_re),
    .raddr_i (cmd_i.point_index),
    .rdata_o (ns_rdata)
  );

  fpnb_ram #(
    .WIDTH (fpnb_pkg::PT_W),
    .DEPTH (fpnb_pkg::MAX_SITES)
  ) u_site_list_ram (
    .clk_i   (clk_i),
    .we_i    (sl_we),
    .waddr_i (sl_waddr),
    .wdata_i (sl_wdata),
    .re_i    (sl_re),
    .raddr_i (cmd_i.site_index),
    .rdata_o (sl_rdata)
  );

  fpnb_dist_unit u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag),
    .coord_i (coord_rdata),
    .nreq_o  (nreq),
    .res_o   (dres),
    .busy_o  (dist_busy)
  );

endmodule

>>> rtl/fpnb_ram.sv
// ----------------------------------------------------------------------------
// fpnb_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module fpnb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/fpnb_dist_unit.sv
// ----------------------------------------------------------------------------
// fpnb_dist_unit
// Squared distance pipeline: site coordinate cache, abs difference, square,
// accumulate over all dimensions of one point.
// ----------------------------------------------------------------------------
module fpnb_dist_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fpnb_pkg::tag_t                         tag_i,
  input  logic signed [fpnb_pkg::COORD_BITS-1:0] coord_i,
  output fpnb_pkg::nreq_t                        nreq_o,
  output fpnb_pkg::dres_t                        res_o,
  output logic                                   busy_o
);

  fpnb_pkg::tag_t s1_q, s2_q, s3_q;
  fpnb_pkg::tag_t s2_d;
  logic           res_valid_q;

  logic signed [fpnb_pkg::COORD_BITS-1:0] site_coord_q [fpnb_pkg::DIMS];
  logic [fpnb_pkg::COORD_BITS-1:0]        diff_q;
  logic [fpnb_pkg::SQ_W-1:0]              sq_q;
  logic [fpnb_pkg::DIST_W-1:0]            acc_q;
  logic [fpnb_pkg::PT_W-1:0]              res_point_q;
  logic [fpnb_pkg::DIST_W-1:0]            res_dist_q;

  logic signed [fpnb_pkg::COORD_BITS:0]   delta;
  logic signed [fpnb_pkg::COORD_BITS:0]   delta_abs;
  logic [fpnb_pkg::DIST_W:0]              sum;
  logic [fpnb_pkg::DIST_W-1:0]            sum_sat;

  always_comb begin
    delta     = {coord_i[fpnb_pkg::COORD_BITS-1], coord_i}
              - {site_coord_q[s1_q.dim][fpnb_pkg::COORD_BITS-1], site_coord_q[s1_q.dim]};
    delta_abs = delta[fpnb_pkg::COORD_BITS] ? -delta : delta;
  end

  // site coordinate loads stop at the cache
  always_comb begin
    s2_d       = s1_q;
    s2_d.valid = s1_q.valid & ~s1_q.load_site;
  end

  // saturating accumulation, restarted at the first dimension
  always_comb begin
    sum = (s3_q.first ? '0 : {1'b0, acc_q}) + (fpnb_pkg::DIST_W + 1)'(sq_q);
    if (sum > {1'b0, fpnb_pkg::DIST_MAX}) begin
      sum_sat = fpnb_pkg::DIST_MAX;
    end else begin
      sum_sat = sum[fpnb_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      s3_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      s1_q        <= tag_i;
      s2_q        <= s2_d;
      s3_q        <= s2_q;
      res_valid_q <= s3_q.valid & s3_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q.valid && s1_q.load_site) begin
      site_coord_q[s1_q.dim] <= coord_i;
    end
    diff_q <= delta_abs[fpnb_pkg::COORD_BITS-1:0];
    sq_q   <= diff_q * diff_q;
    if (s3_q.valid) begin
      acc_q <= sum_sat;
    end
    if (s3_q.valid && s3_q.last) begin
      res_point_q <= s3_q.point;
      res_dist_q  <= sum_sat;
    end
  end

  assign nreq_o.valid = s3_q.valid & s3_q.last;
  assign nreq_o.point = s3_q.point;
  assign res_o.valid  = res_valid_q;
  assign res_o.point  = res_point_q;
  assign res_o.dsq    = res_dist_q;
  assign busy_o       = s1_q.valid | s2_q.valid | s3_q.valid | res_valid_q;

endmodule

>>> rtl/fpnb_checker.sv
// ----------------------------------------------------------------------------
// fpnb_checker
// Port-level checks of the farthest point net builder, bound to the top.
// ----------------------------------------------------------------------------
module fpnb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cmd_valid_i,
  input logic                          cmd_ready_i,
  input logic [1:0]                    cmd_kind_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [1:0]                    rsp_status_i,
  input logic [fpnb_pkg::PT_W-1:0]     rsp_point_id_i,
  input logic [fpnb_pkg::DIST_W-1:0]   rsp_sq_distance_i
);

  // a stalled response stays
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_status_i) && $stable(rsp_point_id_i)
      && $stable(rsp_sq_distance_i))
    else $error("response payload changed while stalled");

  // a command transfer needs a free response slot
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |-> !rsp_valid_i || rsp_ready_i)
    else $error("command taken while a response is pending");

  a_load_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i && cmd_kind_i == fpnb_pkg::KIND_LOAD |=> rsp_valid_i)
    else $error("load response not produced in the next cycle");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != fpnb_pkg::STATUS_OK |->
      rsp_point_id_i == '0 && rsp_sq_distance_i == '0)
    else $error("error response carries data");

endmodule

bind farthest_point_net_builder_unit fpnb_checker u_fpnb_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .cmd_valid_i       (cmd_i.valid),
  .cmd_ready_i       (cmd_i.ready),
  .cmd_kind_i        (cmd_i.kind),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_status_i      (rsp_o.status),
  .rsp_point_id_i    (rsp_o.point_id),
  .rsp_sq_distance_i (rsp_o.sq_distance)
);

>>> tb/farthest_point_net_builder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// farthest_point_net_builder_unit_test
// Drives coordinate loads, selection runs and site/cell reads into the net
// builder under random sender bursts and receiver stalls, predicts every
// response with an in-bench greedy farthest point model and checks them in
// order. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module farthest_point_net_builder_unit_test;
  import fpnb_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1200;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_LIMIT  = 300000;

  typedef struct packed {
    kind_e                         kind;
    logic [PT_W-1:0]               point;
    logic [DIM_W-1:0]              dim;
    logic signed [COORD_BITS-1:0]  value;
    logic [SITE_W-1:0]             site;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [PT_W-1:0]   point_id;
    logic [DIST_W-1:0] sq_distance;
  } reply_t;

  typedef enum {SPREAD_FULL, SPREAD_NARROW, SPREAD_EXTREME} spread_e;
  typedef enum {READY_ALWAYS, READY_COIN, READY_CADENCE, READY_SPARSE} ready_e;

  logic clk;
  logic rst_n;

  fpnb_cfg_if cfg_if ();
  fpnb_cmd_if cmd_if ();
  fpnb_rsp_if rsp_if ();

  farthest_point_net_builder_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  // predictor state
  logic signed [COORD_BITS-1:0] coord_mem [MAX_POINTS*DIMS];
  logic [DIST_W-1:0]            near_dist [MAX_POINTS];
  logic [PT_W-1:0]              near_site [MAX_POINTS];
  logic [PT_W-1:0]              net_sites [MAX_SITES];
  logic [DIST_W-1:0]            net_sep;
  logic [PT_W-1:0]              net_far;
  bit                           net_built;
  int unsigned                  net_points;
  int unsigned                  net_count;
  logic [NPTS_W-1:0]            reg_points = PTS_RESET;
  logic [NSITE_W-1:0]           reg_sites  = SITES_RESET;

  cmd_t   pending_cmds [$];
  reply_t expected_replies [$];
  bit     coord_set [MAX_POINTS*DIMS];
  spread_e coord_mode = SPREAD_FULL;

  int unsigned error_count;
  int unsigned cmds_issued;
  int unsigned runs_done;
  int unsigned replies_seen;
  int unsigned quiet_cycles;
  bit          cmd_taken;
  bit          hold_req;
  bit          hold_seen;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  function automatic int unsigned clamp_count(input int unsigned v, input int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [DIST_W-1:0] pair_dist(input int unsigned a, input int unsigned b);
    longint          diff;
    longint unsigned total;
    total = 0;
    for (int d = 0; d < DIMS; d++) begin
      diff = longint'(coord_mem[a*DIMS+d]) - longint'(coord_mem[b*DIMS+d]);
      if (diff < 0) diff = -diff;
      if (diff >= (longint'(1) << 20)) return DIST_MAX;
      total += diff * diff;
      if (total > DIST_MAX) return DIST_MAX;
    end
    return total[DIST_W-1:0];
  endfunction

  // greedy selection: site 0 first, then the point farthest from all sites
  function automatic void build_net();
    int unsigned       n;
    int unsigned       m;
    int unsigned       far_pt;
    int unsigned       s;
    logic [DIST_W-1:0] sep;
    logic [DIST_W-1:0] dd;
    bit                found;
    n = clamp_count(reg_points, MAX_POINTS);
    m = clamp_count(reg_sites, MAX_SITES);
    far_pt = 0;
    sep = '0;
    found = 1'b0;
    net_sites[0] = '0;
    for (int p = 0; p < n; p++) begin
      dd = pair_dist(0, p);
      near_dist[p] = dd;
      near_site[p] = '0;
      if (!found || dd > sep) begin
        far_pt = p;
        sep = dd;
        found = 1'b1;
      end
    end
    for (int i = 1; i < m; i++) begin
      s = far_pt;
      net_sites[i] = PT_W'(s);
      found = 1'b0;
      for (int p = 0; p < n; p++) begin
        dd = pair_dist(s, p);
        // equal distance keeps the earlier site
        if (dd < near_dist[p]) begin
          near_dist[p] = dd;
          near_site[p] = PT_W'(s);
        end
        if (!found || near_dist[p] > sep) begin
          far_pt = p;
          sep = near_dist[p];
          found = 1'b1;
        end
      end
    end
    net_sep = sep;
    net_far = PT_W'(far_pt);
    net_points = n;
    net_count = m;
    net_built = 1'b1;
  endfunction

  function automatic reply_t predict_reply(input cmd_t c);
    reply_t r;
    r.status = STATUS_OK;
    r.point_id = '0;
    r.sq_distance = '0;
    case (c.kind)
      KIND_LOAD: begin
        coord_mem[int'(c.point)*DIMS + int'(c.dim)] = c.value;
      end
      KIND_RUN: begin
        build_net();
        r.point_id = net_far;
        r.sq_distance = net_sep;
      end
      KIND_READ_SITE: begin
        if (!net_built) r.status = STATUS_NO_RUN;
        else if (c.site >= net_count) r.status = STATUS_RANGE;
        else r.point_id = net_sites[c.site];
      end
      default: begin
        if (!net_built) r.status = STATUS_NO_RUN;
        else if (c.point >= net_points) r.status = STATUS_RANGE;
        else begin
          r.point_id = near_site[c.point];
          r.sq_distance = near_dist[c.point];
        end
      end
    endcase
    return r;
  endfunction

  // command driver: bursts of random length with random gaps
  int unsigned burst_left;
  int unsigned gap_left;

  always @(negedge clk) begin
    cmd_t nxt;
    if (!rst_n) begin
      cmd_if.valid       <= 1'b0;
      cmd_if.kind        <= KIND_LOAD;
      cmd_if.point_index <= '0;
      cmd_if.coord_index <= '0;
      cmd_if.coord_value <= '0;
      cmd_if.site_index  <= '0;
    end else if (!cmd_if.valid || cmd_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        cmd_if.valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        nxt = pending_cmds.pop_front();
        cmd_if.valid       <= 1'b1;
        cmd_if.kind        <= nxt.kind;
        cmd_if.point_index <= nxt.point;
        cmd_if.coord_index <= nxt.dim;
        cmd_if.coord_value <= nxt.value;
        cmd_if.site_index  <= nxt.site;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                    : $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // response stall pattern, plus a long hold-off on request
  ready_e      ready_mode = READY_ALWAYS;
  int unsigned mode_left;
  int unsigned ready_tick;
  int unsigned hold_left;

  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 200);
      end
      mode_left--;
      ready_tick++;
      case (ready_mode)
        READY_ALWAYS:  rsp_if.ready <= 1'b1;
        READY_COIN:    rsp_if.ready <= 1'($urandom_range(0, 1));
        READY_CADENCE: rsp_if.ready <= (ready_tick % 4) != 3;
        default:       rsp_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // monitor: register writes, response checks, command predictions
  always @(posedge clk) begin
    cmd_t   seen;
    reply_t want;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == CFG_POINTS_IN_USE) reg_points = cfg_if.data[NPTS_W-1:0];
        else if (cfg_if.index == CFG_SITES_WANTED) reg_sites = cfg_if.data[NSITE_W-1:0];
      end
      if (rsp_if.valid && rsp_if.ready) begin
        replies_seen++;
        if (expected_replies.size() == 0) begin
          report_mismatch("response with nothing pending", 64'(rsp_if.point_id), 0);
        end else begin
          want = expected_replies.pop_front();
          if (rsp_if.status !== want.status)
            report_mismatch("status", 64'(rsp_if.status), 64'(want.status));
          if (rsp_if.point_id !== want.point_id)
            report_mismatch("point_id", 64'(rsp_if.point_id), 64'(want.point_id));
          if (rsp_if.sq_distance !== want.sq_distance)
            report_mismatch("sq_distance", 64'(rsp_if.sq_distance), 64'(want.sq_distance));
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        seen.kind  = kind_e'(cmd_if.kind);
        seen.point = cmd_if.point_index;
        seen.dim   = cmd_if.coord_index;
        seen.value = cmd_if.coord_value;
        seen.site  = cmd_if.site_index;
        if (seen.kind == KIND_RUN) runs_done++;
        expected_replies = {expected_replies, predict_reply(seen)};
      end
    end
    cmd_taken <= rst_n && cmd_if.valid && cmd_if.ready;
  end

  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int pick_coord();
    case (coord_mode)
      SPREAD_FULL:   return int'($urandom);
      SPREAD_NARROW: return $urandom_range(0, 4) - 2;
      default: begin
        case ($urandom_range(0, 3))
          0:       return -32768;
          1:       return 32767;
          2:       return -1;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  task automatic push_cmd(input kind_e k, input int unsigned pt, input int unsigned dim,
                          input int v, input int unsigned site);
    cmd_t c;
    c.kind  = k;
    c.point = PT_W'(pt);
    c.dim   = DIM_W'(dim);
    c.value = COORD_BITS'(v);
    c.site  = SITE_W'(site);
    if (k == KIND_LOAD) coord_set[int'(c.point)*DIMS + int'(c.dim)] = 1'b1;
    pending_cmds = {pending_cmds, c};
    cmds_issued++;
  endtask

  // every coordinate a run will read must be loaded first
  task automatic fill_points(input int unsigned n);
    for (int p = 0; p < n; p++)
      for (int d = 0; d < DIMS; d++)
        if (!coord_set[p*DIMS+d]) push_cmd(KIND_LOAD, p, d, pick_coord(), $urandom);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_if.valid || expected_replies.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CFG_DAT_W'(val);
    do @(posedge clk);
    while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    int unsigned pts_raw;
    int unsigned sites_raw;
    int unsigned n_eff;
    int unsigned m_eff;
    int unsigned pick;
    int unsigned phase_no;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reads before any run
    push_cmd(KIND_READ_SITE, 0, 0, 0, 0);
    push_cmd(KIND_READ_CELL, MAX_POINTS - 1, 0, 0, MAX_SITES - 1);
    drain();

    // zero register values saturate to one point and one site
    write_reg(CFG_POINTS_IN_USE, 0);
    write_reg(CFG_SITES_WANTED, 0);
    for (int d = 0; d < DIMS; d++) push_cmd(KIND_LOAD, 0, d, (d % 2) ? 32767 : -32768, 0);
    push_cmd(KIND_RUN, 0, 0, 0, 0);
    push_cmd(KIND_READ_SITE, 0, 0, 0, 0);
    push_cmd(KIND_READ_SITE, 0, 0, 0, 1);
    push_cmd(KIND_READ_CELL, 0, 0, 0, 0);
    push_cmd(KIND_READ_CELL, 1, 0, 0, 0);
    drain();

    // duplicate point and opposite corner: ties, and sites picked again
    write_reg(CFG_POINTS_IN_USE, 3);
    write_reg(CFG_SITES_WANTED, (1 << NSITE_W) - 1);
    for (int d = 0; d < DIMS; d++) begin
      push_cmd(KIND_LOAD, 1, d, (d % 2) ? 32767 : -32768, 0);
      push_cmd(KIND_LOAD, 2, d, (d % 2) ? -32768 : 32767, 0);
    end
    push_cmd(KIND_RUN, 0, 0, 0, 0);
    push_cmd(KIND_READ_SITE, 0, 0, 0, MAX_SITES - 1);
    push_cmd(KIND_READ_SITE, 0, 0, 0, 2);
    push_cmd(KIND_READ_CELL, 1, 0, 0, 0);
    push_cmd(KIND_READ_CELL, 2, 0, 0, 0);
    drain();

    phase_no = 0;
    while (cmds_issued < ITEM_TARGET) begin
      phase_no++;
      coord_mode = spread_e'($urandom_range(0, 2));
      pts_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 24);
      if ($urandom_range(0, 7) == 0) begin
        // many sites: keep the point count tiny so the run stays short
        sites_raw = $urandom_range(200, (1 << NSITE_W) - 1);
        if (pts_raw > 4) pts_raw = $urandom_range(2, 4);
      end else begin
        sites_raw = $urandom_range(1, 12);
      end
      // bits above the register width are dropped
      sites_raw |= $urandom_range(0, 15) << NSITE_W;
      n_eff = clamp_count(pts_raw, MAX_POINTS);
      m_eff = clamp_count(sites_raw & ((1 << NSITE_W) - 1), MAX_SITES);
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_POINTS_IN_USE, pts_raw);
        write_reg(CFG_SITES_WANTED, sites_raw);
      end else begin
        write_reg(CFG_SITES_WANTED, sites_raw);
        write_reg(CFG_POINTS_IN_USE, pts_raw);
      end
      if (phase_no % 8 == 1) hold_req = ~hold_req;
      fill_points(n_eff);
      push_cmd(KIND_RUN, $urandom, $urandom, $urandom, $urandom);
      repeat ($urandom_range(30, 70)) begin
        pick = $urandom_range(0, 19);
        if (pick < 7) begin
          push_cmd(KIND_LOAD, ($urandom_range(0, 3) != 0) ? $urandom_range(0, n_eff - 1)
                                                          : $urandom_range(0, MAX_POINTS - 1),
                   $urandom_range(0, DIMS - 1), pick_coord(), $urandom);
        end else if (pick < 9) begin
          push_cmd(KIND_RUN, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 14) begin
          push_cmd(KIND_READ_SITE, $urandom, $urandom, $urandom,
                   ($urandom_range(0, 4) != 0) ? $urandom_range(0, m_eff - 1)
                                               : $urandom_range(0, MAX_SITES - 1));
        end else begin
          push_cmd(KIND_READ_CELL, ($urandom_range(0, 4) != 0) ? $urandom_range(0, n_eff - 1)
                                                               : $urandom_range(0, MAX_POINTS - 1),
                   $urandom, $urandom, $urandom);
        end
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (expected_replies.size() != 0)
      report_mismatch("responses never returned", 0, 64'(expected_replies.size()));
    $display("summary: %0d commands in %0d random phases, %0d selection runs, %0d responses",
             cmds_issued, phase_no, runs_done, replies_seen);
    $display("summary: nets of up to 24 points and up to %0d sites, zero and oversized settings",
             MAX_SITES);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
